@@ sv/kst_pkg.sv @@
// Package for the key slot table: sizes, field types, operation codes,
// the token that walks the cell chain and the slot claim broadcast.
// No dependencies.
package kst_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [7:0]       slot_t;
  typedef logic [15:0]      key_t;
  typedef logic [31:0]      epoch_t;

  typedef enum logic [1:0] {
    OP_ACQUIRE     = 2'd0,
    OP_RELEASE     = 2'd1,
    OP_RELEASE_ALL = 2'd2,
    OP_QUERY       = 2'd3
  } op_e;

  // Request token handed from cell to cell, one hop per cycle.
  typedef struct packed {
    op_e    op;
    key_t   key;
    slot_t  qslot;
    logic   found;     // a used slot holding key was seen upstream
    idx_t   hit_idx;
    logic   free_vld;  // a free slot (1 and up) was seen upstream
    idx_t   free_idx;
    epoch_t epoch;     // query result
  } tok_t;

  // One-cycle broadcast that writes a newly claimed slot.
  typedef struct packed {
    logic vld;
    idx_t idx;
    key_t key;
  } claim_t;

  // Epoch increment, wrapping past zero to one.
  function automatic epoch_t bump_epoch(epoch_t e);
    epoch_t n;
    n = e + epoch_t'(1);
    return (n == '0) ? epoch_t'(1) : n;
  endfunction

endpackage

@@ sv/kst_cell.sv @@
// One slot of the key slot table: key, used flag and epoch, plus the
// token stage that forwards a request to the next slot.
// Depends on kst_pkg.
module kst_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kst_pkg::idx_t   idx_i,
  input  kst_pkg::key_t   dflt_i,
  input  kst_pkg::claim_t claim_i,
  input  logic            vld_i,
  input  kst_pkg::tok_t   tok_i,
  output logic            vld_o,
  output kst_pkg::tok_t   tok_o
);

  logic            used_q, used_d;
  kst_pkg::key_t   key_q, key_d;
  kst_pkg::epoch_t epoch_q, epoch_d;
  logic            vld_q;
  kst_pkg::tok_t   tok_q, tok_d;

  logic            is_zero;
  logic            fill;
  logic            eff_used;
  kst_pkg::key_t   eff_key;
  logic            match;

  always_comb begin
    is_zero  = (idx_i == '0);
    // slot 0 takes the default key on first non-query request
    fill     = vld_i && is_zero && (tok_i.op != kst_pkg::OP_QUERY) && !used_q;
    eff_used = used_q | fill;
    eff_key  = fill ? dflt_i : key_q;
    match    = eff_used && (eff_key == tok_i.key);

    tok_d   = tok_i;
    used_d  = eff_used;
    key_d   = eff_key;
    epoch_d = fill ? kst_pkg::bump_epoch(epoch_q) : epoch_q;

    if (vld_i) begin
      case (tok_i.op)
        kst_pkg::OP_ACQUIRE: begin
          if (match && !tok_i.found) begin
            tok_d.found   = 1'b1;
            tok_d.hit_idx = idx_i;
          end
          if (!eff_used && !is_zero && !tok_i.free_vld) begin
            tok_d.free_vld = 1'b1;
            tok_d.free_idx = idx_i;
          end
        end
        kst_pkg::OP_RELEASE: begin
          // first match only; the default key is never released
          if (match && !tok_i.found && (tok_i.key != dflt_i)) begin
            tok_d.found = 1'b1;
            used_d      = 1'b0;
            key_d       = '0;
          end
        end
        kst_pkg::OP_RELEASE_ALL: begin
          if (!is_zero) begin
            used_d = 1'b0;
            key_d  = '0;
          end
        end
        kst_pkg::OP_QUERY: begin
          if (tok_i.qslot == kst_pkg::slot_t'(idx_i)) begin
            tok_d.epoch = epoch_q;
          end
        end
        default: ;
      endcase
    end

    if (claim_i.vld && (claim_i.idx == idx_i)) begin
      used_d  = 1'b1;
      key_d   = claim_i.key;
      epoch_d = kst_pkg::bump_epoch(epoch_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      key_q   <= '0;
      epoch_q <= '0;
      vld_q   <= 1'b0;
    end else begin
      used_q  <= used_d;
      key_q   <= key_d;
      epoch_q <= epoch_d;
      vld_q   <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

@@ sv/key_slot_table_with_epochs_unit.sv @@
// Top level of the key slot table with per-slot epochs.
// Holds the request controller and the chain of kst_cell slots.
// Depends on kst_pkg and kst_cell.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the operation
//   (acquire, release, release all, epoch query), tdata the key code and
//   the query slot. Each request yields exactly one result transfer on
//   m_axis: tuser carries the ok flag, tdata the slot index and epoch.
//   The default key register is written through cfg_valid_i/cfg_data_i;
//   cfg_ready_o is always high. Write it only while the block is idle.
//
// Timing:
//   A request walks the row of SLOTS cells, one slot per cycle. The result
//   is then registered in the pending result register and loaded into the
//   output register, and the next request is taken only after that load,
//   so a request is not accepted while the previous one is in the chain.
//   A newly claimed slot is written by a one-cycle broadcast right after
//   the walk, before the next request enters the chain.
//
// Reset clears all slots (keys, used flags, epochs) and the default key.
// A stalled result waits in the output register; one further request is
// accepted and walked meanwhile, and its result is held until the output
// register frees.
module key_slot_table_with_epochs_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write: default key
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] key_code, [23:16] query_slot
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] slot_index, [39:8] epoch_value
  output logic [0:0]  m_axis_tuser    // [0] ok
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e          state_q;
  kst_pkg::key_t   dflt_q;

  // head of the chain
  logic            launch_vld_q;
  kst_pkg::tok_t   launch_tok_q;
  kst_pkg::tok_t   fresh_tok;

  // slot claim broadcast
  kst_pkg::claim_t claim_q;

  // result waiting for the output register
  logic            pend_ok_q;
  kst_pkg::slot_t  pend_idx_q;
  kst_pkg::epoch_t pend_epoch_q;
  kst_pkg::claim_t pend_claim_q;

  // output register
  logic            out_vld_q;
  logic            out_ok_q;
  kst_pkg::slot_t  out_idx_q;
  kst_pkg::epoch_t out_epoch_q;

  // chain links: entry g feeds cell g
  logic            chain_vld [kst_pkg::SLOTS+1];
  kst_pkg::tok_t   chain_tok [kst_pkg::SLOTS+1];

  // result decode of the token leaving the last cell
  kst_pkg::tok_t   fin;
  logic            res_ok;
  kst_pkg::slot_t  res_idx;
  kst_pkg::epoch_t res_epoch;
  kst_pkg::claim_t res_claim;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_epoch_q, out_idx_q};
  assign m_axis_tuser  = out_ok_q;

  always_comb begin
    fresh_tok          = '0;
    fresh_tok.op       = kst_pkg::op_e'(s_axis_tuser);
    fresh_tok.key      = s_axis_tdata[15:0];
    fresh_tok.qslot    = s_axis_tdata[23:16];
  end

  assign chain_vld[0] = launch_vld_q;
  assign chain_tok[0] = launch_tok_q;

  for (genvar g = 0; g < kst_pkg::SLOTS; g++) begin : g_cell
    kst_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (kst_pkg::idx_t'(g)),
      .dflt_i (dflt_q),
      .claim_i(claim_q),
      .vld_i  (chain_vld[g]),
      .tok_i  (chain_tok[g]),
      .vld_o  (chain_vld[g+1]),
      .tok_o  (chain_tok[g+1])
    );
  end

  always_comb begin
    fin       = chain_tok[kst_pkg::SLOTS];
    res_ok    = 1'b0;
    res_idx   = '0;
    res_epoch = '0;
    res_claim = '0;
    case (fin.op)
      kst_pkg::OP_ACQUIRE: begin
        if (fin.found) begin
          res_ok  = 1'b1;
          res_idx = kst_pkg::slot_t'(fin.hit_idx);
        end else if (fin.free_vld) begin
          res_ok        = 1'b1;
          res_idx       = kst_pkg::slot_t'(fin.free_idx);
          res_claim.vld = 1'b1;
          res_claim.idx = fin.free_idx;
          res_claim.key = fin.key;
        end
      end
      kst_pkg::OP_QUERY: res_epoch = fin.epoch;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= '0;
    end else if (cfg_valid_i) begin
      dflt_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      launch_vld_q <= 1'b0;
      launch_tok_q <= '0;
      claim_q      <= '0;
      pend_ok_q    <= 1'b0;
      pend_idx_q   <= '0;
      pend_epoch_q <= '0;
      pend_claim_q <= '0;
      out_vld_q    <= 1'b0;
      out_ok_q     <= 1'b0;
      out_idx_q    <= '0;
      out_epoch_q  <= '0;
    end else begin
      launch_vld_q <= 1'b0;
      claim_q.vld  <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            launch_vld_q <= 1'b1;
            launch_tok_q <= fresh_tok;
            state_q      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chain_vld[kst_pkg::SLOTS]) begin
            pend_ok_q    <= res_ok;
            pend_idx_q   <= res_idx;
            pend_epoch_q <= res_epoch;
            pend_claim_q <= res_claim;
            state_q      <= ST_DONE;
          end
        end
        ST_DONE: begin
          // load result once the output register is free or draining
          if (!out_vld_q || m_axis_tready) begin
            out_vld_q   <= 1'b1;
            out_ok_q    <= pend_ok_q;
            out_idx_q   <= pend_idx_q;
            out_epoch_q <= pend_epoch_q;
            claim_q     <= pend_claim_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  logic [kst_pkg::SLOTS:0] chain_vld_vec;
  always_comb begin
    for (int i = 0; i <= kst_pkg::SLOTS; i++) begin
      chain_vld_vec[i] = chain_vld[i];
    end
  end

  // only one request is ever in the chain
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(chain_vld_vec) <= 1)
    else $error("more than one token in the cell chain");

  // a token leaves the chain only while the controller waits for it
  a_exit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_vld[kst_pkg::SLOTS] |-> (state_q == ST_SCAN))
    else $error("token left the chain outside the scan state");

  // a claim write never overlaps a token in the chain
  a_claim_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    claim_q.vld |-> (chain_vld_vec == '0))
    else $error("slot claim overlaps a token in the chain");

  // a failed or non-acquire result reports slot 0
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[7:0] == '0))
    else $error("slot index set without ok");
`endif

endmodule
